FILE: hdl/actuated_traffic_light_controller_top_macros.svh
// Assertion macros for the actuated traffic light controller.
// Included by the top level; depends on nothing else.
`ifndef ACTUATED_TRAFFIC_LIGHT_CONTROLLER_TOP_MACROS_SVH
`define ACTUATED_TRAFFIC_LIGHT_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATLC_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATLC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/atlc_pkg.sv
// Shared types, codes and constants of the actuated traffic light controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package atlc_pkg;

	localparam int TIME_BITS_DEF = 21;
	localparam int DUR_W = 20;
	localparam int CYC_W = 22;
	localparam int DT_W = 16;
	localparam int DEM_W = 4;
	localparam int IDX_W = 3;
	localparam int PH_W = 2;
	localparam int LIGHT_W = 2;

	localparam logic [DUR_W-1:0] NS_GREEN_RST = DUR_W'(30000);
	localparam logic [DUR_W-1:0] EW_GREEN_RST = DUR_W'(30000);
	localparam logic [DUR_W-1:0] ORANGE_RST = DUR_W'(3000);
	localparam logic [DUR_W-1:0] MIN_GREEN_RST = DUR_W'(5000);
	localparam logic [DUR_W-1:0] MAX_RED_RST = DUR_W'(60000);

	localparam logic [IDX_W-1:0] REG_NS_GREEN = 3'd0;
	localparam logic [IDX_W-1:0] REG_EW_GREEN = 3'd1;
	localparam logic [IDX_W-1:0] REG_ORANGE = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_GREEN = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_RED = 3'd4;

	localparam logic [PH_W-1:0] PH_NS_GREEN = 2'd0;
	localparam logic [PH_W-1:0] PH_NS_ORANGE = 2'd1;
	localparam logic [PH_W-1:0] PH_EW_GREEN = 2'd2;
	localparam logic [PH_W-1:0] PH_EW_ORANGE = 2'd3;

	localparam logic [LIGHT_W-1:0] LIGHT_RED = 2'd0;
	localparam logic [LIGHT_W-1:0] LIGHT_ORANGE = 2'd1;
	localparam logic [LIGHT_W-1:0] LIGHT_GREEN = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADJ,
		ST_CHK,
		ST_MOD,
		ST_STEP
	} state_t;

	typedef struct packed {
		logic load;
		logic adjust;
		logic mod_start;
		logic mod_step;
		logic advance;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic need_mod;
		logic mod_last;
		logic step_more;
	} stat_t;

endpackage

FILE: hdl/actuated_traffic_light_controller_top.sv
// Top level of the actuated traffic light controller: controller, datapath
// and the result register. Depends on atlc_pkg, atlc_ctrl, atlc_dp and the
// assertion macro header.
//
//   Channel  Direction  Signals
//   in       sink       in_valid, in_ready, dt_ms, demand
//   out      source     out_valid, out_ready, phase, ns_light, ew_light
//   cfg      sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A tick loads the inputs, adjusts and checks the timer, then takes its
// phase steps one at a time. A phase timer that reaches a full cycle is
// first reduced by a bit-serial modulo unit, one remainder bit per cycle.
// Reset clears the phase to north-south green and all timers to zero.
// A result waits in the output register while the next tick is accepted.
// Configuration writes are taken in every cycle.
`include "actuated_traffic_light_controller_top_macros.svh"

module actuated_traffic_light_controller_top
	import atlc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [DT_W-1:0]    dt_ms,
	input  logic [DEM_W-1:0]   demand,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PH_W-1:0]    phase,
	output logic [LIGHT_W-1:0] ns_light,
	output logic [LIGHT_W-1:0] ew_light,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [DUR_W-1:0]   cfg_data
);

	cmd_t            cmd;
	stat_t           stat;
	logic [PH_W-1:0] dp_phase;
	logic            out_valid_q;
	logic [PH_W-1:0] phase_q;
	logic            out_free;

	function automatic logic [LIGHT_W-1:0] light_of(input logic [PH_W-1:0] ph,
		input logic [PH_W-1:0] green_ph);
		if (ph == green_ph) begin
			return LIGHT_GREEN;
		end else if (ph == green_ph + PH_W'(1)) begin
			return LIGHT_ORANGE;
		end
		return LIGHT_RED;
	endfunction

	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	atlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	atlc_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dt_ms     (dt_ms),
		.demand    (demand),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.cur_phase (dp_phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			phase_q <= dp_phase;
		end
	end

	assign out_valid = out_valid_q;
	assign phase = phase_q;
	assign ns_light = light_of(phase_q, PH_NS_GREEN);
	assign ew_light = light_of(phase_q, PH_EW_GREEN);

	`ATLC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "Input ready stayed high right after a transfer.")
	`ATLC_ASSERT_IMPL(a_publish_slot_free, clk, arst_n, cmd.publish, !out_valid_q || out_ready, "A result was published over one not yet transferred.")
	`ATLC_ASSERT_IMPL(a_one_axis_moving, clk, arst_n, out_valid, ns_light == LIGHT_RED || ew_light == LIGHT_RED, "Both axes show a non-red light.")

endmodule

FILE: hdl/atlc_ctrl.sv
// Controller state machine of the actuated traffic light controller.
// Sequences load, adjust, modulo and phase steps; depends on atlc_pkg.
module atlc_ctrl
	import atlc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  out_free,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_ADJ;
				end
			end
			ST_ADJ: begin
				cmd.adjust = 1'b1;
				state_nxt = ST_CHK;
			end
			ST_CHK: begin
				if (stat.need_mod) begin
					cmd.mod_start = 1'b1;
					state_nxt = ST_MOD;
				end else begin
					state_nxt = ST_STEP;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_nxt = ST_STEP;
				end
			end
			ST_STEP: begin
				if (stat.step_more) begin
					cmd.advance = 1'b1;
				end else if (out_free) begin
					cmd.publish = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/atlc_dp.sv
// Datapath of the actuated traffic light controller: registers, timers,
// hold and early-end logic, a bit-serial modulo unit and the phase stepper.
// Depends on atlc_pkg.
module atlc_dp
	import atlc_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DT_W-1:0]  dt_ms,
	input  logic [DEM_W-1:0] demand,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0] cfg_data,
	input  cmd_t             cmd,
	output stat_t            stat,
	output logic [PH_W-1:0]  cur_phase
);

	localparam int TMR_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
	localparam int CMP_W = (TMR_W > CYC_W) ? TMR_W : CYC_W;
	localparam int CNT_W = $clog2(TMR_W);
	localparam logic [TMR_W:0] TMR_MAX_X =
		{{(TMR_W + 1 - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(TMR_W - 1);

	logic [DUR_W-1:0] ns_green_q;
	logic [DUR_W-1:0] ew_green_q;
	logic [DUR_W-1:0] orange_q;
	logic [DUR_W-1:0] min_green_q;
	logic [DUR_W-1:0] max_red_q;

	logic [PH_W-1:0]      phase_q;
	logic [TMR_W-1:0]     timer_q;
	logic [TIME_BITS-1:0] ns_red_q;
	logic [TIME_BITS-1:0] ew_red_q;
	logic                 ns_dem_q;
	logic                 ew_dem_q;
	logic [CYC_W-1:0]     cycle_q;
	logic [TMR_W-1:0]     div_q;
	logic [CYC_W-1:0]     rem_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [DUR_W-1:0]     d_ns_green;
	logic [DUR_W-1:0]     d_ew_green;
	logic [DUR_W-1:0]     d_orange;
	logic [DUR_W-1:0]     dur;
	logic [TMR_W:0]       timer_sum;
	logic [TMR_W-1:0]     timer_add;
	logic [TIME_BITS:0]   ns_red_sum;
	logic [TIME_BITS:0]   ew_red_sum;
	logic [TIME_BITS-1:0] ns_red_add;
	logic [TIME_BITS-1:0] ew_red_add;
	logic [CMP_W-1:0]     timer_x;
	logic [CMP_W-1:0]     dur_x;
	logic [CMP_W-1:0]     held_x;
	logic [CMP_W-1:0]     adj_x;
	logic                 hold;
	logic                 early;
	logic [CYC_W-1:0]     cycle_sum;
	logic [CYC_W:0]       shifted;
	logic [CYC_W:0]       diff;
	logic [CYC_W-1:0]     rem_nxt;

	function automatic logic [DUR_W-1:0] nonzero(input logic [DUR_W-1:0] v);
		return (v == '0) ? DUR_W'(1) : v;
	endfunction

	assign d_ns_green = nonzero(ns_green_q);
	assign d_ew_green = nonzero(ew_green_q);
	assign d_orange = nonzero(orange_q);

	always_comb begin
		case (phase_q)
			PH_NS_GREEN: dur = d_ns_green;
			PH_EW_GREEN: dur = d_ew_green;
			default:     dur = d_orange;
		endcase
	end

	assign timer_sum = {1'b0, timer_q} + (TMR_W + 1)'(dt_ms);
	assign timer_add = (timer_sum > TMR_MAX_X) ? TMR_MAX_X[TMR_W-1:0] : timer_sum[TMR_W-1:0];
	assign ns_red_sum = {1'b0, ns_red_q} + (TIME_BITS + 1)'(dt_ms);
	assign ew_red_sum = {1'b0, ew_red_q} + (TIME_BITS + 1)'(dt_ms);
	assign ns_red_add = ns_red_sum[TIME_BITS] ? '1 : ns_red_sum[TIME_BITS-1:0];
	assign ew_red_add = ew_red_sum[TIME_BITS] ? '1 : ew_red_sum[TIME_BITS-1:0];

	assign timer_x = CMP_W'(timer_q);
	assign dur_x = CMP_W'(dur);

	always_comb begin
		hold = ((phase_q == PH_NS_GREEN) && ns_dem_q && !ew_dem_q) ||
			((phase_q == PH_EW_GREEN) && ew_dem_q && !ns_dem_q);
		held_x = (hold && (timer_x >= dur_x)) ? (dur_x - CMP_W'(1)) : timer_x;
		early = 1'b0;
		if (held_x >= CMP_W'(min_green_q)) begin
			if (phase_q == PH_NS_GREEN) begin
				early = (ew_dem_q && (CMP_W'(ew_red_q) >= CMP_W'(max_red_q))) ||
					(!ns_dem_q && ew_dem_q);
			end else if (phase_q == PH_EW_GREEN) begin
				early = (ns_dem_q && (CMP_W'(ns_red_q) >= CMP_W'(max_red_q))) ||
					(!ew_dem_q && ns_dem_q);
			end
		end
		adj_x = early ? dur_x : held_x;
	end

	assign cycle_sum = CYC_W'(d_ns_green) + CYC_W'(d_orange) + CYC_W'(d_ew_green) +
		CYC_W'(d_orange);

	assign shifted = {rem_q, div_q[TMR_W-1]};
	assign diff = shifted - {1'b0, cycle_q};
	assign rem_nxt = (shifted >= {1'b0, cycle_q}) ? diff[CYC_W-1:0] : shifted[CYC_W-1:0];

	assign stat.need_mod = timer_x >= CMP_W'(cycle_q);
	assign stat.mod_last = cnt_q == '0;
	assign stat.step_more = timer_x >= dur_x;
	assign cur_phase = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_green_q <= NS_GREEN_RST;
			ew_green_q <= EW_GREEN_RST;
			orange_q <= ORANGE_RST;
			min_green_q <= MIN_GREEN_RST;
			max_red_q <= MAX_RED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NS_GREEN:  ns_green_q <= cfg_data;
				REG_EW_GREEN:  ew_green_q <= cfg_data;
				REG_ORANGE:    orange_q <= cfg_data;
				REG_MIN_GREEN: min_green_q <= cfg_data;
				REG_MAX_RED:   max_red_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NS_GREEN;
			timer_q <= '0;
			ns_red_q <= '0;
			ew_red_q <= '0;
		end else begin
			if (cmd.load) begin
				timer_q <= timer_add;
				ns_red_q <= (phase_q >= PH_EW_GREEN) ? ns_red_add : '0;
				ew_red_q <= (phase_q <= PH_NS_ORANGE) ? ew_red_add : '0;
			end else if (cmd.adjust) begin
				timer_q <= TMR_W'(adj_x);
			end else if (cmd.mod_step && stat.mod_last) begin
				timer_q <= TMR_W'(rem_nxt);
			end else if (cmd.advance) begin
				timer_q <= TMR_W'(timer_x - dur_x);
				phase_q <= phase_q + PH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ns_dem_q <= |demand[1:0];
			ew_dem_q <= |demand[3:2];
		end
		if (cmd.adjust) begin
			cycle_q <= cycle_sum;
		end
		if (cmd.mod_start) begin
			div_q <= timer_q;
			rem_q <= '0;
			cnt_q <= CNT_TOP;
		end else if (cmd.mod_step) begin
			div_q <= div_q << 1;
			rem_q <= rem_nxt;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule
